FILE: design/hbsa_pkg.sv
package hbsa_pkg;

  // Widest bitmap word the priority encoder handles.
  localparam int MaxWordBits = 64;
  localparam int PosW        = 6;

  // Width of the slot number on the ports.
  localparam int SlotW = 12;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_TOP,
    S_A_MID,
    S_A_BOT,
    S_REL0,
    S_REL1,
    S_REL2,
    S_REL3
  } state_e;

  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  localparam logic ST_DONE      = 1'b0;
  localparam logic ST_EXHAUSTED = 1'b1;

  // Index of the lowest set bit; zero for an all-zero word.
  function automatic logic [PosW-1:0] lowest_set(input logic [MaxWordBits-1:0] w);
    logic [PosW-1:0] r;
    r = '0;
    for (int i = MaxWordBits - 1; i >= 0; i--) begin
      if (w[i]) begin
        r = PosW'(i);
      end
    end
    return r;
  endfunction

endpackage

FILE: design/hierarchical_bitmap_slot_allocator.sv
// Allocate: from accept the sequencer searches the top, middle and bottom maps in turn,
// dropping any stale top or middle summary bit and searching again; an exhausted pool is
// reported from the top search. Release: two passes through the shared divide-by-LEVEL_BITS
// unit, then read-modify-write of the bottom and middle bitmap memories; an out-of-range
// release skips these and is answered from idle. One item at a time; results are shown for
// one cycle and cannot be stalled. After reset the block is busy while it fills the maps.
module hierarchical_bitmap_slot_allocator #(
  parameter int LEVEL_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        req_type_i,
  input  logic [hbsa_pkg::SlotW-1:0]  slot_id_i,
  output logic                        valid_o,
  output logic                        status_o,
  output logic [hbsa_pkg::SlotW-1:0]  granted_slot_o
);

  localparam int SW         = hbsa_pkg::SlotW;
  localparam int MaxW       = hbsa_pkg::MaxWordBits;
  localparam int LW         = $clog2(LEVEL_BITS);
  localparam int BotWords   = LEVEL_BITS * LEVEL_BITS;
  localparam int BAW        = $clog2(BotWords);
  localparam int SlotCount  = LEVEL_BITS * LEVEL_BITS * LEVEL_BITS;
  localparam int RecipShift = 24;
  localparam int RW         = 25;
  localparam int Recip      = ((2 ** RecipShift) + LEVEL_BITS - 1) / LEVEL_BITS;
  localparam int PW         = SW + RW;

  localparam logic [LEVEL_BITS-1:0] WordOne  = LEVEL_BITS'(1);
  localparam logic [LEVEL_BITS-1:0] WordOnes = '1;

  hbsa_pkg::state_e state_q, state_d;

  logic [LEVEL_BITS-1:0] top_q, top_d;
  logic [BAW-1:0]        cnt_q, cnt_d;
  logic [SW-1:0]         sid_q, sid_d;
  logic [SW-1:0]         q1_q, q1_d;
  logic [LW-1:0]         q2_q, q2_d;
  logic [LW-1:0]         bot_q, bot_d;
  logic [LW-1:0]         mid_q, mid_d;
  logic [LW-1:0]         t_q, t_d;
  logic [LW-1:0]         m_q, m_d;
  logic [LEVEL_BITS-1:0] mw_q, mw_d;
  logic [BAW-1:0]        bidx_q, bidx_d;
  logic                  valid_q, valid_d;
  logic                  status_q, status_d;
  logic [SW-1:0]         slot_q, slot_d;

  // Bitmap memories.
  logic [LEVEL_BITS-1:0] mid_mem [LEVEL_BITS];
  logic [LEVEL_BITS-1:0] bot_mem [BotWords];
  logic [LEVEL_BITS-1:0] mid_rd_q, bot_rd_q;
  logic                  mid_we, bot_we;
  logic [LW-1:0]         mid_wa, mid_ra;
  logic [BAW-1:0]        bot_wa, bot_ra;
  logic [LEVEL_BITS-1:0] mid_wd, bot_wd;

  // Shared divide-by-LEVEL_BITS unit: reciprocal multiply, then remainder from the registered quotient.
  logic [SW-1:0] div_x, div_quo;
  logic [PW-1:0] div_prod;
  logic [SW-1:0] rem_x, rem_quo, rem_full;

  logic [hbsa_pkg::PosW-1:0] enc_full;
  logic [LW-1:0]             enc_pos;
  logic [LEVEL_BITS-1:0]     enc_word;
  logic [LEVEL_BITS-1:0]     bw_new, mw_new;

  always_comb begin
    div_x    = (state_q == hbsa_pkg::S_REL0) ? sid_q : q1_q;
    div_prod = PW'(div_x) * PW'(Recip);
    div_quo  = div_prod[RecipShift+SW-1:RecipShift];
    if (state_q == hbsa_pkg::S_REL1) begin
      rem_x   = sid_q;
      rem_quo = q1_q;
    end else begin
      rem_x   = q1_q;
      rem_quo = SW'(q2_q);
    end
    rem_full = rem_x - SW'(rem_quo * SW'(LEVEL_BITS));
  end

  always_comb begin
    case (state_q)
      hbsa_pkg::S_A_TOP: enc_word = top_q;
      hbsa_pkg::S_A_MID: enc_word = mid_rd_q;
      default:           enc_word = bot_rd_q;
    endcase
    enc_full = hbsa_pkg::lowest_set(MaxW'(enc_word));
    enc_pos  = enc_full[LW-1:0];
    bw_new   = bot_rd_q & ~(WordOne << enc_pos);
    mw_new   = mw_q & ~(WordOne << m_q);
  end

  always_comb begin
    state_d  = state_q;
    top_d    = top_q;
    cnt_d    = cnt_q;
    sid_d    = sid_q;
    q1_d     = q1_q;
    q2_d     = q2_q;
    bot_d    = bot_q;
    mid_d    = mid_q;
    t_d      = t_q;
    m_d      = m_q;
    mw_d     = mw_q;
    bidx_d   = bidx_q;
    valid_d  = 1'b0;
    status_d = status_q;
    slot_d   = slot_q;
    mid_we   = 1'b0;
    mid_wa   = t_q;
    mid_wd   = mw_new;
    mid_ra   = enc_pos;
    bot_we   = 1'b0;
    bot_wa   = bidx_q;
    bot_wd   = bw_new;
    bot_ra   = bidx_q;

    case (state_q)
      hbsa_pkg::S_CLEAR: begin
        // Slot 0 starts out reserved.
        bot_we = 1'b1;
        bot_wa = cnt_q;
        bot_wd = (cnt_q == '0) ? (WordOnes & ~WordOne) : WordOnes;
        if (32'(cnt_q) < LEVEL_BITS) begin
          mid_we = 1'b1;
          mid_wa = cnt_q[LW-1:0];
          mid_wd = WordOnes;
        end
        cnt_d = cnt_q + BAW'(1);
        if (32'(cnt_q) == BotWords - 1) begin
          state_d = hbsa_pkg::S_IDLE;
        end
      end

      hbsa_pkg::S_IDLE: begin
        if (start_i) begin
          sid_d = slot_id_i;
          if (req_type_i == hbsa_pkg::REQ_ALLOC) begin
            state_d = hbsa_pkg::S_A_TOP;
          end else if (32'(slot_id_i) >= SlotCount) begin
            valid_d  = 1'b1;
            status_d = hbsa_pkg::ST_DONE;
            slot_d   = '0;
          end else begin
            state_d = hbsa_pkg::S_REL0;
          end
        end
      end

      hbsa_pkg::S_A_TOP: begin
        if (top_q == '0) begin
          valid_d  = 1'b1;
          status_d = hbsa_pkg::ST_EXHAUSTED;
          slot_d   = '0;
          state_d  = hbsa_pkg::S_IDLE;
        end else begin
          t_d     = enc_pos;
          mid_ra  = enc_pos;
          state_d = hbsa_pkg::S_A_MID;
        end
      end

      hbsa_pkg::S_A_MID: begin
        if (mid_rd_q == '0) begin
          // Stale top bit: drop it and search again.
          top_d   = top_q & ~(WordOne << t_q);
          state_d = hbsa_pkg::S_A_TOP;
        end else begin
          m_d     = enc_pos;
          mw_d    = mid_rd_q;
          bidx_d  = BAW'(32'(t_q) * LEVEL_BITS + 32'(enc_pos));
          bot_ra  = BAW'(32'(t_q) * LEVEL_BITS + 32'(enc_pos));
          state_d = hbsa_pkg::S_A_BOT;
        end
      end

      hbsa_pkg::S_A_BOT: begin
        if (bot_rd_q == '0) begin
          // Stale middle bit: clear it and search again.
          mid_we  = 1'b1;
          state_d = hbsa_pkg::S_A_TOP;
        end else begin
          bot_we = 1'b1;
          if (bw_new == '0) begin
            mid_we = 1'b1;
            if (mw_new == '0) begin
              top_d = top_q & ~(WordOne << t_q);
            end
          end
          valid_d  = 1'b1;
          status_d = hbsa_pkg::ST_DONE;
          slot_d   = SW'(32'(bidx_q) * LEVEL_BITS + 32'(enc_pos));
          state_d  = hbsa_pkg::S_IDLE;
        end
      end

      hbsa_pkg::S_REL0: begin
        q1_d    = div_quo;
        state_d = hbsa_pkg::S_REL1;
      end

      hbsa_pkg::S_REL1: begin
        // q1 is also the index of the bottom word.
        bot_d   = rem_full[LW-1:0];
        q2_d    = div_quo[LW-1:0];
        bot_ra  = q1_q[BAW-1:0];
        state_d = hbsa_pkg::S_REL2;
      end

      hbsa_pkg::S_REL2: begin
        mid_d   = rem_full[LW-1:0];
        bot_we  = 1'b1;
        bot_wa  = q1_q[BAW-1:0];
        bot_wd  = bot_rd_q | (WordOne << bot_q);
        mid_ra  = q2_q;
        state_d = hbsa_pkg::S_REL3;
      end

      hbsa_pkg::S_REL3: begin
        mid_we   = 1'b1;
        mid_wa   = q2_q;
        mid_wd   = mid_rd_q | (WordOne << mid_q);
        top_d    = top_q | (WordOne << q2_q);
        valid_d  = 1'b1;
        status_d = hbsa_pkg::ST_DONE;
        slot_d   = '0;
        state_d  = hbsa_pkg::S_IDLE;
      end

      default: begin
        state_d = hbsa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hbsa_pkg::S_CLEAR;
      top_q   <= WordOnes;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sid_q    <= sid_d;
    q1_q     <= q1_d;
    q2_q     <= q2_d;
    bot_q    <= bot_d;
    mid_q    <= mid_d;
    t_q      <= t_d;
    m_q      <= m_d;
    mw_q     <= mw_d;
    bidx_q   <= bidx_d;
    status_q <= status_d;
    slot_q   <= slot_d;
  end

  always_ff @(posedge clk_i) begin
    if (mid_we) begin
      mid_mem[mid_wa] <= mid_wd;
    end
    mid_rd_q <= mid_mem[mid_ra];
  end

  always_ff @(posedge clk_i) begin
    if (bot_we) begin
      bot_mem[bot_wa] <= bot_wd;
    end
    bot_rd_q <= bot_mem[bot_ra];
  end

  assign busy_o         = (state_q != hbsa_pkg::S_IDLE);
  assign valid_o        = valid_q;
  assign status_o       = status_q;
  assign granted_slot_o = slot_q;

  // A result is only shown once the sequencer is back at rest.
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |-> !busy_o)
    else $error("result strobe while busy");

  // An exhausted pool never reports a slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == hbsa_pkg::ST_EXHAUSTED) |-> (granted_slot_o == '0))
    else $error("exhausted result carries a slot");

  // The fill pass runs only once after reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != hbsa_pkg::S_CLEAR) |=> (state_q != hbsa_pkg::S_CLEAR))
    else $error("fill pass restarted");

  // A grant clears exactly one bit of the bottom word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hbsa_pkg::S_A_BOT && bot_rd_q != '0) |->
      (bot_we && $countones(bot_wd) + 1 == $countones(bot_rd_q)))
    else $error("grant did not clear a single bottom bit");

  // A release always leaves its top summary bit set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hbsa_pkg::S_REL3) |=> (top_q[q2_q] == 1'b1))
    else $error("release left top bit clear");

endmodule
